FILE: src/rrcsa_pkg.sv
// Shared widths, defaults and operation codes of the round-robin color slot allocator.
package rrcsa_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int OPCODE_W  = 2;
    localparam int CLIENT_W  = 5;
    localparam int SLOT_W    = 6;
    localparam int TOTAL_W   = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD     = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

endpackage

FILE: src/rrcsa_if.sv
// Request and response channel interfaces of the round-robin color slot allocator.
interface rrcsa_req_if;
    import rrcsa_pkg::*;

    logic                valid;
    logic                ready;
    t_op                 opcode;
    logic [CLIENT_W-1:0] client;
    logic                unique_only;

    modport source (output valid, opcode, client, unique_only, input ready);
    modport sink   (input valid, opcode, client, unique_only, output ready);
endinterface

interface rrcsa_rsp_if;
    import rrcsa_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] client_total;
    logic               rejected;

    modport source (output valid, slot, client_total, rejected, input ready);
    modport sink   (input valid, slot, client_total, rejected, output ready);
endinterface

FILE: src/round_robin_color_slot_allocator_top.sv
// Round-robin color slot allocator: holder matrix in a single-port-read memory with a sequencer.
//
// The block keeps a SLOTS x SLOTS holder matrix (row s, bit c: client c holds slot s) in a
// synchronous memory with one write port and one registered read port, plus a client count.
// Every request yields exactly one response; N below is the client count at acceptance.
// Add, clear and any rejected request go straight to the response state. Advance streams
// the rows through the read port one per cycle: it scans up to N rows for the client's
// current slot, then up to N candidate rows round-robin, then adds the client's bit to the
// chosen row and clears it from the old row. Remove sweeps rows 0 to N - 1 with a
// read-modify-write per row. One request is worked on at a time; a new request is accepted
// from the cycle after the previous response has been moved into the output register, so a
// slow consumer does not block the next request. Only add writes a row at or above the
// client count: it writes the row at the count and raises the count, so the next add slot
// always equals the client count and the count doubles as that pointer. Reset and clear mark
// every row empty at once through per-row valid bits; no clearing pass is needed.
module round_robin_color_slot_allocator_top #(
    parameter int SLOTS = rrcsa_pkg::SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrcsa_req_if.sink    i_req,
    rrcsa_rsp_if.source  o_rsp
);
    import rrcsa_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;       // row index width
    localparam int CW = $clog2(SLOTS + 1);                      // count width, holds SLOTS
    localparam int XW = (CW > CLIENT_W) ? CW : CLIENT_W;        // compare width for client

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_SEEK  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_SWEEP = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    // Holder matrix storage and its read port.
    logic [SLOTS-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [SLOTS-1:0] r_vld;

    logic             rd_en;
    logic [SW-1:0]    rd_addr;
    logic             wr_en;
    logic [SW-1:0]    wr_addr;
    logic [SLOTS-1:0] wr_data;
    logic             clr_all;

    // Sequencer state.
    t_state           r_state,   n_state;
    logic [CW-1:0]    r_count,   n_count;
    logic [CW-1:0]    r_iss,     n_iss;      // next row to read
    logic [CW-1:0]    r_nis,     n_nis;      // candidates read so far
    logic             r_pend,    n_pend;     // read data arrives this cycle
    logic [SW-1:0]    r_chk,     n_chk;      // row whose data arrives
    logic             r_found,   n_found;
    logic [SW-1:0]    r_cur,     n_cur;
    logic [SLOTS-1:0] r_cur_row, n_cur_row;
    logic [SLOTS-1:0] r_bit,     n_bit;
    logic             r_uniq,    n_uniq;
    logic [CW-1:0]    r_res_slot, n_res_slot;
    logic             r_res_rej, n_res_rej;

    // Response register.
    logic               r_out_vld,   n_out_vld;
    logic [SLOT_W-1:0]  r_out_slot,  n_out_slot;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_rej,   n_out_rej;

    logic [SLOTS-1:0] req_bit;
    logic [XW-1:0]    client_x;
    logic [SLOTS-1:0] row_q;
    logic             row_zero;
    logic             row_one;
    logic             row_ok;
    logic [CW-1:0]    chk_next;
    logic [CW-1:0]    iss_next;

    assign client_x = XW'(i_req.client);

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            req_bit[j] = (client_x == XW'(j));
        end
    end

    // A row never written since reset or clear reads as empty.
    assign row_q    = r_rd_vld ? r_rd_data : '0;
    assign row_zero = (row_q == '0);
    assign row_one  = !row_zero && ((row_q & (row_q - SLOTS'(1))) == '0);
    assign row_ok   = row_zero || (!r_uniq && row_one);
    assign chk_next = CW'(r_chk) + CW'(1);
    assign iss_next = r_iss + CW'(1);

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.slot         = r_out_slot;
    assign o_rsp.client_total = r_out_total;
    assign o_rsp.rejected     = r_out_rej;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_iss       = r_iss;
        n_nis       = r_nis;
        n_pend      = r_pend;
        n_chk       = r_chk;
        n_found     = r_found;
        n_cur       = r_cur;
        n_cur_row   = r_cur_row;
        n_bit       = r_bit;
        n_uniq      = r_uniq;
        n_res_slot  = r_res_slot;
        n_res_rej   = r_res_rej;
        n_out_vld   = r_out_vld;
        n_out_slot  = r_out_slot;
        n_out_total = r_out_total;
        n_out_rej   = r_out_rej;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        clr_all     = 1'b0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_bit      = req_bit;
                    n_uniq     = i_req.unique_only;
                    n_res_slot = CW'(SLOTS);
                    n_res_rej  = 1'b0;
                    n_iss      = '0;
                    n_nis      = '0;
                    n_pend     = 1'b0;
                    n_found    = 1'b0;
                    unique case (i_req.opcode)
                        OP_ADD: begin
                            // The row at the count is always empty, so the client bit is
                            // written without a read.
                            if (r_count >= CW'(SLOTS) || client_x >= XW'(SLOTS)) begin
                                n_res_rej = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = r_count[SW-1:0];
                                wr_data    = req_bit;
                                n_res_slot = r_count;
                                n_count    = r_count + CW'(1);
                            end
                            n_state = S_RESP;
                        end
                        OP_ADVANCE: begin
                            if (client_x >= XW'(r_count)) begin
                                n_res_rej = 1'b1;
                                n_state   = S_RESP;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        OP_REMOVE: begin
                            if (client_x >= XW'(r_count)) begin
                                n_res_rej = 1'b1;
                                n_state   = S_RESP;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        OP_CLEAR: begin
                            clr_all = 1'b1;
                            n_count = '0;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_FIND: begin
                if (r_pend && ((row_q & r_bit) != '0)) begin
                    n_found    = 1'b1;
                    n_cur      = r_chk;
                    n_cur_row  = row_q;
                    n_res_slot = CW'(r_chk);
                    n_iss      = (chk_next == r_count) ? '0 : chk_next;
                    n_nis      = '0;
                    n_pend     = 1'b0;
                    n_state    = S_SEEK;
                end else if (!r_pend && r_iss == r_count) begin
                    n_iss   = '0;
                    n_nis   = '0;
                    n_state = S_SEEK;
                end else if (r_iss < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_iss[SW-1:0];
                    n_chk   = r_iss[SW-1:0];
                    n_iss   = iss_next;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end

            S_SEEK: begin
                if (r_pend && row_ok) begin
                    n_res_slot = CW'(r_chk);
                    n_pend     = 1'b0;
                    if (r_found && r_chk == r_cur) begin
                        n_state = S_RESP;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_chk;
                        wr_data = row_q | r_bit;
                        n_state = r_found ? S_MOVE : S_RESP;
                    end
                end else if (!r_pend && r_nis == r_count) begin
                    n_state = S_RESP;
                end else if (r_nis < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_iss[SW-1:0];
                    n_chk   = r_iss[SW-1:0];
                    n_iss   = (iss_next == r_count) ? '0 : iss_next;
                    n_nis   = r_nis + CW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end

            S_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = r_cur_row & ~r_bit;
                n_state = S_RESP;
            end

            S_SWEEP: begin
                // Write back row r_chk while row r_chk + 1 is being read.
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_chk;
                    wr_data = row_q & ~r_bit;
                end
                if (!r_pend && r_iss == r_count) begin
                    n_state = S_RESP;
                end else if (r_iss < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_iss[SW-1:0];
                    n_chk   = r_iss[SW-1:0];
                    n_iss   = iss_next;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end

            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_slot  = SLOT_W'(r_res_slot);
                    n_out_total = TOTAL_W'(r_count);
                    n_out_rej   = r_res_rej;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
            if (clr_all) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_iss       <= n_iss;
        r_nis       <= n_nis;
        r_chk       <= n_chk;
        r_cur       <= n_cur;
        r_cur_row   <= n_cur_row;
        r_bit       <= n_bit;
        r_uniq      <= n_uniq;
        r_res_slot  <= n_res_slot;
        r_res_rej   <= n_res_rej;
        r_out_slot  <= n_out_slot;
        r_out_total <= n_out_total;
        r_out_rej   <= n_out_rej;
    end

    // Holder matrix memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // The client count never passes the number of slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("client count above slot count");

    // The client's bit is cleared from the old row only right after a move target was written.
    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> $past(r_state == S_SEEK) && $past(wr_en))
        else $error("move write without a preceding target write");

    // A write and a read in the same cycle never touch the same row.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same row in one cycle");

    // The candidate search reads no more rows than there are clients.
    a_seek_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK) |-> (r_nis <= r_count))
        else $error("candidate search overran the client count");

    // An accepted request always leaves the idle state.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

endmodule
